### design/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    // base + off modulo DEPTH, base below DEPTH, off at most DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/deq_ifs.sv
`default_nettype none

interface deq_cmd_if
    import deq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] entry;
    logic                    last;

    modport source (output valid, status, entry, last, input ready);
    modport sink   (input valid, status, entry, last, output ready);
endinterface

`default_nettype wire

### design/deq_front.sv
`default_nettype none

module deq_front
    import deq_pkg::*;
(
    deq_cmd_if.sink  i_cmd,
    output logic     o_q_valid,
    input  wire      i_q_ready,
    output t_cmd     o_q_cmd
);

    logic legal;

    // unused op codes are taken and dropped here, they cause no result
    always_comb begin
        legal          = (i_cmd.op <= OP_W'(OP_LIST));
        o_q_cmd.op     = t_op'(i_cmd.op);
        o_q_cmd.value  = i_cmd.value;
        o_q_valid      = i_cmd.valid && legal;
        i_cmd.ready    = i_q_ready || !legal;
    end

endmodule

`default_nettype wire

### design/deq_cmdq.sv
`default_nettype none

module deq_cmdq
    import deq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push_valid,
    output logic  o_push_ready,
    input  t_cmd  i_push_cmd,
    output logic  o_pop_valid,
    input  wire   i_pop_ready,
    output t_cmd  o_pop_cmd
);

    t_cmd              r_slot [QDEPTH];
    logic [QIDX_W-1:0] r_wr_ptr;
    logic [QIDX_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QIDX_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QIDX_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

### design/deq_back.sv
`default_nettype none

module deq_back
    import deq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    deq_rsp_if.source  o_rsp
);

    typedef enum logic {
        S_EXEC,
        S_LIST
    } t_state;

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_front, n_front;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_k, n_k;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic signed [VAL_W-1:0] r_out_entry, n_out_entry;
    logic                    r_out_last, n_out_last;

    logic [VAL_W-1:0]        r_store [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    logic                    can_load;
    logic                    take;
    logic                    full;
    logic                    empty;
    logic                    list_end;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        front_dec;

    assign can_load    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == S_EXEC) && can_load;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign list_end    = (CNT_W'(r_k) + CNT_W'(1) == r_count);
    assign front_dec   = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - IDX_W'(1);

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = front_dec;
        rd_en        = 1'b0;
        rd_addr      = r_front;

        case (r_state)
            S_EXEC: begin
                if (take) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_entry  = '0;
                    n_out_last   = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = front_dec;
                                n_front = front_dec;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = ring_add(r_front, r_count);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_front = ring_add(r_front, CNT_W'(1));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_LIST: begin
                            if (empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                // first read goes out now, results follow from S_LIST
                                n_out_valid = r_out_valid && !o_rsp.ready;
                                rd_en       = 1'b1;
                                rd_addr     = r_front;
                                n_k         = '0;
                                n_state     = S_LIST;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !o_rsp.ready;
                        end
                    endcase
                end
            end
            S_LIST: begin
                // r_rd_data holds entry k until it is loaded into the output register
                if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_entry  = r_rd_data;
                    n_out_last   = list_end;
                    if (list_end) begin
                        n_state = S_EXEC;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = ring_add(r_front, CNT_W'(r_k) + CNT_W'(1));
                    end
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_front     <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.entry  = r_out_entry;
    assign o_rsp.last   = r_out_last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_list_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (CNT_W'(r_k) < r_count))
        else $error("listing index beyond held entries");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == OP_PUSH_BACK && !full) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push back did not grow the queue");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> r_out_last)
        else $error("failure status without last");
`endif

endmodule

`default_nettype wire

### design/double_ended_queue.sv
// Push and pop: the command is stored in the command queue, then its result is registered,
// one such operation per cycle when the result side keeps up and no listing runs.
// Listing of n entries: n results, one per cycle when the result side keeps up,
// after a first read, paced by the single registered read port of the entry store.
// Reset is synchronous, active low: clears front index, count and command
// queue; the entry store is not cleared and needs no clearing pass.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_rsp_if.source  o_rsp
);

    logic q_in_valid;
    logic q_in_ready;
    t_cmd q_in_cmd;
    logic q_out_valid;
    logic q_out_ready;
    t_cmd q_out_cmd;

    deq_front u_front (
        .i_cmd     (i_cmd),
        .o_q_valid (q_in_valid),
        .i_q_ready (q_in_ready),
        .o_q_cmd   (q_in_cmd)
    );

    deq_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_in_valid),
        .o_push_ready (q_in_ready),
        .i_push_cmd   (q_in_cmd),
        .o_pop_valid  (q_out_valid),
        .i_pop_ready  (q_out_ready),
        .o_pop_cmd    (q_out_cmd)
    );

    deq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_out_valid),
        .o_cmd_ready (q_out_ready),
        .i_cmd       (q_out_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
